### rtl/assert_macros.svh
// Assertion macros shared by the tokenizer checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is high.
`define DT_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tokenizer check failed");

// Clocked check that also holds while reset is high.
`define DT_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tokenizer check failed");

`endif

### rtl/dsl_tok_pkg.sv
// Shared types, constants and helper functions of the character stream tokenizer.
package dsl_tok_pkg;

  // Default widths of the internal position and value counters.
  localparam int LINE_BITS_DEF   = 16;
  localparam int COLUMN_BITS_DEF = 16;
  localparam int OFFSET_BITS_DEF = 24;
  localparam int NUMBER_BITS_DEF = 32;

  // Widths of the fields carried on the ports.
  localparam int CH_W   = 8;
  localparam int KIND_W = 4;
  localparam int LINE_W = 16;
  localparam int COL_W  = 16;
  localparam int OFF_W  = 24;
  localparam int LEN_W  = 16;
  localparam int VAL_W  = 32;
  localparam int BAD_W  = 8;

  // Result tdata layout, lowest field first.
  localparam int TD_LINE_LO = 0;
  localparam int TD_COL_LO  = TD_LINE_LO + LINE_W;
  localparam int TD_OFF_LO  = TD_COL_LO + COL_W;
  localparam int TD_LEN_LO  = TD_OFF_LO + OFF_W;
  localparam int TD_VAL_LO  = TD_LEN_LO + LEN_W;
  localparam int TD_OVF_LO  = TD_VAL_LO + VAL_W;
  localparam int TD_BAD_LO  = TD_OVF_LO + 1;
  localparam int DATA_W     = TD_BAD_LO + BAD_W;
  localparam int OUT_TDATA_W = ((DATA_W + 7) / 8) * 8;

  // Depth of the result queue.
  localparam int Q_DEPTH = 4;

  // Token kinds.
  localparam logic [KIND_W-1:0] K_EOF    = 4'd0;
  localparam logic [KIND_W-1:0] K_NUMBER = 4'd1;
  localparam logic [KIND_W-1:0] K_IDENT  = 4'd2;
  localparam logic [KIND_W-1:0] K_KW0    = 4'd3;
  localparam logic [KIND_W-1:0] K_PLUS   = 4'd8;
  localparam logic [KIND_W-1:0] K_MINUS  = 4'd9;
  localparam logic [KIND_W-1:0] K_COLON  = 4'd10;
  localparam logic [KIND_W-1:0] K_SEMI   = 4'd11;
  localparam logic [KIND_W-1:0] K_EQUAL  = 4'd12;
  localparam logic [KIND_W-1:0] K_LEQ    = 4'd13;
  localparam logic [KIND_W-1:0] K_ERROR  = 4'd14;

  // Characters with a meaning of their own.
  localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CH_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CH_W-1:0] CH_PLUS  = "+";
  localparam logic [CH_W-1:0] CH_MINUS = "-";
  localparam logic [CH_W-1:0] CH_COLON = ":";
  localparam logic [CH_W-1:0] CH_SEMI  = ";";
  localparam logic [CH_W-1:0] CH_EQUAL = "=";
  localparam logic [CH_W-1:0] CH_LESS  = "<";
  localparam logic [CH_W-1:0] CH_SLASH = "/";
  localparam logic [CH_W-1:0] CH_UNDER = "_";

  // Keyword spellings, padded with zeros to four characters.
  localparam int KW_NUM = 5;
  localparam logic [CH_W-1:0] KW_TEXT [KW_NUM][4] = '{
    '{"l", "e", "t", 8'h00},
    '{"i", "f", 8'h00, 8'h00},
    '{"g", "o", "t", "o"},
    '{"o", "u", "t", 8'h00},
    '{"h", "a", "l", "t"}
  };
  localparam logic [2:0] KW_LEN [KW_NUM] = '{3'd3, 3'd2, 3'd4, 3'd3, 3'd4};

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [LINE_W-1:0] line;
    logic [COL_W-1:0]  col;
    logic [OFF_W-1:0]  off;
    logic [LEN_W-1:0]  len;
    logic [VAL_W-1:0]  val;
    logic              ovf;
    logic [BAD_W-1:0]  bad;
    logic              last;
  } tok_t;

  // Up to two tokens produced by one character, packed from slot 0 up.
  typedef struct packed {
    logic [1:0]       valid;
    tok_t [1:0]       rec;
  } scan_out_t;

  function automatic logic is_space(input logic [CH_W-1:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(input logic [CH_W-1:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [CH_W-1:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  // Keywords whose spelling has character c at position pos.
  function automatic logic [KW_NUM-1:0] kw_step(input logic [CH_W-1:0]  c,
                                               input logic [LEN_W-1:0] pos);
    logic [KW_NUM-1:0] m;
    m = '0;
    for (int i = 0; i < KW_NUM; i++) begin
      if ((pos < LEN_W'(KW_LEN[i])) && (KW_TEXT[i][pos[1:0]] == c)) begin
        m[i] = 1'b1;
      end
    end
    return m;
  endfunction

  // Identifier or keyword kind of a finished word.
  function automatic logic [KIND_W-1:0] kw_kind(input logic [KW_NUM-1:0] cand,
                                               input logic [LEN_W-1:0]  len);
    logic [KIND_W-1:0] k;
    k = K_IDENT;
    for (int i = 0; i < KW_NUM; i++) begin
      if (cand[i] && (len == LEN_W'(KW_LEN[i]))) begin
        k = K_KW0 + KIND_W'(i);
      end
    end
    return k;
  endfunction

endpackage

### rtl/dsl_tok_fifo.sv
// Small result queue that takes up to two tokens per cycle and gives one.
module dsl_tok_fifo
  import dsl_tok_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  scan_out_t push,
  input  logic      pop,
  output tok_t      head,
  output logic      not_empty,
  output logic      room
);

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  tok_t             mem [Q_DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [1:0]       npush;

  assign npush      = {1'b0, push.valid[0]} + {1'b0, push.valid[1]};
  assign count_next = count + CNT_W'(npush) - CNT_W'(pop);
  assign not_empty  = (count != '0);
  // Room for the worst case of two new tokens.
  assign room       = (count <= CNT_W'(Q_DEPTH - 2));
  assign head       = mem[rptr];

  always_ff @(posedge clk) begin
    if (push.valid[0]) begin
      mem[wptr] <= push.rec[0];
    end
    if (push.valid[1]) begin
      mem[wptr + PTR_W'(1)] <= push.rec[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + PTR_W'(npush);
      rptr  <= rptr + PTR_W'(pop);
      count <= count_next;
    end
  end

endmodule

### rtl/dsl_tok_scan.sv
// Scanner state and the per-character token logic.
module dsl_tok_scan
  import dsl_tok_pkg::*;
#(
  parameter int LINE_BITS   = LINE_BITS_DEF,
  parameter int COLUMN_BITS = COLUMN_BITS_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic [CH_W-1:0] ch,
  input  logic            eos,
  output scan_out_t       res
);

  localparam logic [2:0] M_IDLE    = 3'd0;
  localparam logic [2:0] M_NUMBER  = 3'd1;
  localparam logic [2:0] M_IDENT   = 3'd2;
  localparam logic [2:0] M_LESS    = 3'd3;
  localparam logic [2:0] M_SLASH   = 3'd4;
  localparam logic [2:0] M_COMMENT = 3'd5;
  localparam logic [2:0] M_QUIET   = 3'd6;

  localparam int WIDE_W = NUMBER_BITS + 4;

  logic [2:0]             mode,     mode_next;
  logic [LINE_BITS-1:0]   cur_line, cur_line_next;
  logic [COLUMN_BITS-1:0] cur_col,  cur_col_next;
  logic [OFFSET_BITS-1:0] cur_off,  cur_off_next;
  logic [LINE_BITS-1:0]   tok_line, tok_line_next;
  logic [COLUMN_BITS-1:0] tok_col,  tok_col_next;
  logic [OFFSET_BITS-1:0] tok_off,  tok_off_next;
  logic [LEN_W-1:0]       tok_len,  tok_len_next;
  logic [NUMBER_BITS-1:0] acc,      acc_next;
  logic                   sat,      sat_next;
  logic [KW_NUM-1:0]      cand,     cand_next;

  logic                   end_in;
  logic                   go_idle;
  logic                   adv;
  logic                   slot;
  logic [WIDE_W-1:0]      wide;
  tok_t                   pend_rec;
  tok_t                   eof_rec;
  tok_t                   tok_err;
  tok_t                   here_rec;
  logic [KIND_W-1:0]      op_kind;
  logic                   op_hit;

  function automatic tok_t make_rec(input logic [KIND_W-1:0]      kind,
                                    input logic [LINE_BITS-1:0]   line,
                                    input logic [COLUMN_BITS-1:0] col,
                                    input logic [OFFSET_BITS-1:0] off,
                                    input logic [LEN_W-1:0]       len,
                                    input logic [NUMBER_BITS-1:0] val,
                                    input logic                   ovf,
                                    input logic [BAD_W-1:0]       bad);
    tok_t r;
    r.kind = kind;
    r.line = LINE_W'(line);
    r.col  = COL_W'(col);
    r.off  = OFF_W'(off);
    r.len  = len;
    r.val  = VAL_W'(val);
    r.ovf  = ovf;
    r.bad  = bad;
    r.last = 1'b0;
    return r;
  endfunction

  assign end_in = eos || (ch == CH_NUL);

  // Decimal step: acc * 10 + digit, built from two shifts.
  assign wide = (WIDE_W'(acc) << 3) + (WIDE_W'(acc) << 1) + WIDE_W'(ch[3:0]);

  assign pend_rec = (mode == M_NUMBER) ?
    make_rec(K_NUMBER, tok_line, tok_col, tok_off, tok_len, acc, sat, '0) :
    make_rec(kw_kind(cand, tok_len), tok_line, tok_col, tok_off, tok_len, '0, 1'b0, '0);
  assign eof_rec = make_rec(K_EOF, cur_line, cur_col, cur_off, '0, '0, 1'b0, '0);
  assign tok_err = make_rec(K_ERROR, tok_line, tok_col, tok_off, LEN_W'(1), '0, 1'b0,
                            (mode == M_LESS) ? CH_LESS : CH_SLASH);

  always_comb begin
    op_hit  = 1'b1;
    op_kind = K_PLUS;
    case (ch)
      CH_PLUS:  op_kind = K_PLUS;
      CH_MINUS: op_kind = K_MINUS;
      CH_COLON: op_kind = K_COLON;
      CH_SEMI:  op_kind = K_SEMI;
      CH_EQUAL: op_kind = K_EQUAL;
      default:  op_hit  = 1'b0;
    endcase
  end

  // Token that starts and ends at the current character.
  assign here_rec = op_hit ?
    make_rec(op_kind, cur_line, cur_col, cur_off, LEN_W'(1), '0, 1'b0, '0) :
    make_rec(K_ERROR, cur_line, cur_col, cur_off, LEN_W'(1), '0, 1'b0, ch);

  always_comb begin
    mode_next     = mode;
    cur_line_next = cur_line;
    cur_col_next  = cur_col;
    cur_off_next  = cur_off;
    tok_line_next = tok_line;
    tok_col_next  = tok_col;
    tok_off_next  = tok_off;
    tok_len_next  = tok_len;
    acc_next      = acc;
    sat_next      = sat;
    cand_next     = cand;
    res           = '0;
    go_idle       = 1'b0;
    adv           = 1'b0;
    slot          = 1'b0;

    if (step && (mode != M_QUIET)) begin
      if (end_in) begin
        if ((mode == M_LESS) || (mode == M_SLASH)) begin
          res.valid[0] = 1'b1;
          res.rec[0]   = tok_err;
        end else if ((mode == M_NUMBER) || (mode == M_IDENT)) begin
          res.valid    = 2'b11;
          res.rec[0]   = pend_rec;
          res.rec[1]   = eof_rec;
        end else begin
          res.valid[0] = 1'b1;
          res.rec[0]   = eof_rec;
        end
        mode_next = M_QUIET;
      end else begin
        case (mode)
          M_NUMBER: begin
            if (is_digit(ch)) begin
              if (wide > WIDE_W'({NUMBER_BITS{1'b1}})) begin
                acc_next = '1;
                sat_next = 1'b1;
              end else begin
                acc_next = wide[NUMBER_BITS-1:0];
              end
              if (tok_len != '1) tok_len_next = tok_len + 1'b1;
              adv = 1'b1;
            end else begin
              res.valid[0] = 1'b1;
              res.rec[0]   = pend_rec;
              go_idle      = 1'b1;
            end
          end
          M_IDENT: begin
            if (is_alpha(ch) || is_digit(ch) || (ch == CH_UNDER)) begin
              cand_next = cand & kw_step(ch, tok_len);
              if (tok_len != '1) tok_len_next = tok_len + 1'b1;
              adv = 1'b1;
            end else begin
              res.valid[0] = 1'b1;
              res.rec[0]   = pend_rec;
              go_idle      = 1'b1;
            end
          end
          M_LESS: begin
            res.valid[0] = 1'b1;
            if (ch == CH_EQUAL) begin
              res.rec[0] = make_rec(K_LEQ, tok_line, tok_col, tok_off, LEN_W'(2),
                                    '0, 1'b0, '0);
              mode_next  = M_IDLE;
              adv        = 1'b1;
            end else begin
              res.rec[0] = tok_err;
              mode_next  = M_QUIET;
            end
          end
          M_SLASH: begin
            if (ch == CH_SLASH) begin
              mode_next = M_COMMENT;
              adv       = 1'b1;
            end else begin
              res.valid[0] = 1'b1;
              res.rec[0]   = tok_err;
              mode_next    = M_QUIET;
            end
          end
          M_COMMENT: begin
            if (ch == CH_LF) mode_next = M_IDLE;
            adv = 1'b1;
          end
          default: go_idle = 1'b1;
        endcase
      end
    end

    // Start of a new token, also right after a word or number has ended.
    if (go_idle) begin
      slot      = res.valid[0];
      mode_next = M_IDLE;
      if (is_space(ch)) begin
        adv = 1'b1;
      end else begin
        tok_line_next = cur_line;
        tok_col_next  = cur_col;
        tok_off_next  = cur_off;
        tok_len_next  = LEN_W'(1);
        if (is_digit(ch)) begin
          acc_next  = NUMBER_BITS'(ch[3:0]);
          sat_next  = 1'b0;
          mode_next = M_NUMBER;
          adv       = 1'b1;
        end else if (is_alpha(ch) || (ch == CH_UNDER)) begin
          cand_next = kw_step(ch, '0);
          mode_next = M_IDENT;
          adv       = 1'b1;
        end else if (ch == CH_LESS) begin
          mode_next = M_LESS;
          adv       = 1'b1;
        end else if (ch == CH_SLASH) begin
          mode_next = M_SLASH;
          adv       = 1'b1;
        end else begin
          res.valid[slot] = 1'b1;
          res.rec[slot]   = here_rec;
          if (op_hit) begin
            adv = 1'b1;
          end else begin
            mode_next = M_QUIET;
          end
        end
      end
    end

    if (adv) begin
      if (cur_off != '1) cur_off_next = cur_off + 1'b1;
      if (ch == CH_LF) begin
        if (cur_line != '1) cur_line_next = cur_line + 1'b1;
        cur_col_next = COLUMN_BITS'(1);
      end else if (cur_col != '1) begin
        cur_col_next = cur_col + 1'b1;
      end
    end

    if (res.valid[1]) begin
      res.rec[1].last = 1'b1;
    end else if (res.valid[0]) begin
      res.rec[0].last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= M_IDLE;
      cur_line <= LINE_BITS'(1);
      cur_col  <= COLUMN_BITS'(1);
      cur_off  <= '0;
    end else begin
      mode     <= mode_next;
      cur_line <= cur_line_next;
      cur_col  <= cur_col_next;
      cur_off  <= cur_off_next;
    end
  end

  always_ff @(posedge clk) begin
    tok_line <= tok_line_next;
    tok_col  <= tok_col_next;
    tok_off  <= tok_off_next;
    tok_len  <= tok_len_next;
    acc      <= acc_next;
    sat      <= sat_next;
    cand     <= cand_next;
  end

endmodule

### rtl/dsl_char_stream_tokenizer.sv
// Top level of the character stream tokenizer.
//
//  channel   direction  tdata                      tuser        tlast
//  s_*       in         ch                         (none)       end_of_source
//  m_*       out        token position and value   token_kind   last_of_run
//
// One character is taken per cycle while s_tready is high. A transfer lands in
// an input register, and the scanner works on it once the queue has room for
// two tokens; it writes its zero, one or two tokens into a four-entry result
// queue, which drives the output ports directly. The queue gives one token per
// cycle while m_tready is high, so long runs of two-token characters slow the input.
// Reset clears the scanner mode, the line, column and offset counters and the
// queue; no clearing pass is needed. Stalls on m_tready back up into the
// queue, and s_tready falls only when the queue cannot take two more tokens.
module dsl_char_stream_tokenizer
  import dsl_tok_pkg::*;
#(
  parameter int LINE_BITS   = LINE_BITS_DEF,
  parameter int COLUMN_BITS = COLUMN_BITS_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // Input character stream.
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [CH_W-1:0]        s_tdata,   // [7:0] ch
  input  logic                   s_tlast,   // end_of_source
  // Token stream.
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // From the lowest bit: start_line, start_column, start_offset, token_length,
  // number_value, number_overflow, bad_char, zero fill.
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic [KIND_W-1:0]      m_tuser,   // token_kind
  output logic                   m_tlast    // last_of_run
);

  logic            in_valid;
  logic [CH_W-1:0] in_ch;
  logic            in_eos;
  logic            step;
  logic            room;
  logic            pop;
  scan_out_t       scan_res;
  tok_t            head;

  // The held character is scanned once the queue has room for two tokens.
  assign step     = in_valid && room;
  assign s_tready = !in_valid || step;
  assign pop      = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // Payload is only loaded on a transfer, so a held character stays put.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_ch  <= s_tdata;
      in_eos <= s_tlast;
    end
  end

  dsl_tok_scan #(
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS),
    .OFFSET_BITS (OFFSET_BITS),
    .NUMBER_BITS (NUMBER_BITS)
  ) u_scan (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .ch   (in_ch),
    .eos  (in_eos),
    .res  (scan_res)
  );

  dsl_tok_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (scan_res),
    .pop       (pop),
    .head      (head),
    .not_empty (m_tvalid),
    .room      (room)
  );

  assign m_tdata = OUT_TDATA_W'({head.bad, head.ovf, head.val, head.len,
                                 head.off, head.col, head.line});
  assign m_tuser = head.kind;
  assign m_tlast = head.last;

endmodule

### rtl/dsl_tok_checker.sv
// Port-level checks of the tokenizer and their attachment to the top level.
`include "assert_macros.svh"

module dsl_tok_checker
  import dsl_tok_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata,
  input logic [KIND_W-1:0]      m_tuser,
  input logic                   m_tlast
);

  logic                                 waiting;
  logic [OUT_TDATA_W+KIND_W:0]          out_word;
  logic [LEN_W-1:0]                     len_f;
  logic [VAL_W-1:0]                     val_f;
  logic [BAD_W-1:0]                     bad_f;
  logic                                 ovf_f;
  logic                                 is_eof;
  logic                                 is_err;
  logic                                 is_num;
  logic                                 side_clear;

  assign waiting    = m_tvalid && !m_tready;
  assign out_word   = {m_tlast, m_tuser, m_tdata};
  assign len_f      = m_tdata[TD_LEN_LO +: LEN_W];
  assign val_f      = m_tdata[TD_VAL_LO +: VAL_W];
  assign bad_f      = m_tdata[TD_BAD_LO +: BAD_W];
  assign ovf_f      = m_tdata[TD_OVF_LO];
  assign is_eof     = (m_tuser == K_EOF);
  assign is_err     = (m_tuser == K_ERROR);
  assign is_num     = (m_tuser == K_NUMBER);
  assign side_clear = (val_f == '0) && !ovf_f && (bad_f == '0);

  // A token that waits does not change.
  `DT_ASSERT(a_out_hold, clk, rst, waiting |=> m_tvalid && $stable(out_word))

  // The queue is empty right after reset.
  `DT_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_tvalid)

  // End of source carries no text.
  `DT_ASSERT(a_eof_len, clk, rst, m_tvalid && is_eof |-> (len_f == '0) && m_tlast)

  // An error token is one character long and closes its run.
  `DT_ASSERT(a_err_shape, clk, rst, m_tvalid && is_err |-> m_tlast && (len_f == LEN_W'(1)))

  // Only numbers carry a value and only errors carry a bad character.
  `DT_ASSERT(a_side_fields, clk, rst, m_tvalid && !is_num && !is_err |-> side_clear)

endmodule

bind dsl_char_stream_tokenizer dsl_tok_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
